// ----- hdl/slc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants for the stop-and-wait link controller.
// ----------------------------------------------------------------------------
package slc_pkg;

  // default width of the time stamps
  localparam int TIME_BITS_DEF = 32;

  // register reset values
  localparam logic [31:0] ACK_TIMEOUT_RESET = 32'd500000;
  localparam logic [31:0] RESEND_RESET      = 32'd30000;

  // sequence wrap limits
  localparam logic [7:0] WRAP_NEW_BELOW = 8'd5;
  localparam logic [7:0] WRAP_OLD_ABOVE = 8'd250;

  // register indexes
  localparam logic REG_ACK_TIMEOUT = 1'b0;
  localparam logic REG_RESEND      = 1'b1;

  // item opcodes
  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_QUEUE = 1'b1;

  // send kinds
  typedef enum logic [1:0] {
    SK_NONE   = 2'd0,
    SK_ACK    = 2'd1,
    SK_FIRST  = 2'd2,
    SK_RESEND = 2'd3
  } send_kind_t;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // one input item
  typedef struct packed {
    logic        opcode;
    logic [31:0] now_us;
    logic        rx_valid;
    logic        rx_is_ack;
    logic        rx_is_connect;
    logic [7:0]  rx_counter;
    logic        pending_is_connect;
  } item_t;

  // one result item
  typedef struct packed {
    send_kind_t  send_kind;
    logic [7:0]  frame_counter;
    logic        proceed;
    logic        deliver;
    logic        link_reset;
  } result_t;

  // configuration values seen by the core
  typedef struct packed {
    logic [31:0] ack_timeout_us;
    logic [31:0] resend_interval_us;
  } cfg_t;

endpackage

// ----- hdl/slc_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_regs
// APB register file holding the ack timeout and the resend interval.
// ----------------------------------------------------------------------------
module slc_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output slc_pkg::cfg_t     cfg
);
  import slc_pkg::*;

  logic ack_timeout_us_sel;
  logic wr_en;

  assign pready             = 1'b1;
  assign wr_en              = psel && penable && pwrite && pready;
  assign ack_timeout_us_sel = (paddr[2] == REG_ACK_TIMEOUT);

  // register write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout_us     <= ACK_TIMEOUT_RESET;
      cfg.resend_interval_us <= RESEND_RESET;
    end else if (wr_en) begin
      if (ack_timeout_us_sel) begin
        cfg.ack_timeout_us <= pwdata;
      end else begin
        cfg.resend_interval_us <= pwdata;
      end
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      REG_ACK_TIMEOUT: prdata = cfg.ack_timeout_us;
      REG_RESEND:      prdata = cfg.resend_interval_us;
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hdl/slc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_core
// Link state and the per-item decision: sends, resends, acks and delivery.
// ----------------------------------------------------------------------------
module slc_core #(
  parameter int TIME_BITS = slc_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  slc_pkg::item_t    item,
  input  slc_pkg::cfg_t     cfg,
  output slc_pkg::result_t  result
);
  import slc_pkg::*;

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  // link state
  logic                 waiting_for_ack, waiting_for_ack_next;
  logic                 send_pending, send_pending_next;
  logic                 pending_connect_kept, pending_connect_kept_next;
  logic [7:0]           last_tx_counter, last_tx_counter_next;
  logic [7:0]           last_rx_counter, last_rx_counter_next;
  logic [7:0]           ack_counter_kept, ack_counter_kept_next;
  logic [TIME_BITS-1:0] sent_time, sent_time_next;
  logic [TIME_BITS-1:0] resent_time, resent_time_next;

  logic [CMP_W-1:0]     now_wide;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] resent_eff;
  logic [TIME_BITS-1:0] since_sent;
  logic [TIME_BITS-1:0] since_resent;
  logic                 timed_out;
  logic                 resend_due;
  logic                 rx_fresh;

  // time arithmetic, modulo the stamp width
  assign now_wide     = CMP_W'(item.now_us);
  assign now          = now_wide[TIME_BITS-1:0];
  assign resent_eff   = (resent_time < sent_time) ? sent_time : resent_time;
  assign since_sent   = now - sent_time;
  assign since_resent = now - resent_eff;
  assign timed_out    = CMP_W'(since_sent) > CMP_W'(cfg.ack_timeout_us);
  assign resend_due   = CMP_W'(since_resent) > CMP_W'(cfg.resend_interval_us);

  // fresh counter, with wraparound near the top
  assign rx_fresh = (item.rx_counter > last_rx_counter) ||
                    ((item.rx_counter < WRAP_NEW_BELOW) &&
                     (last_rx_counter > WRAP_OLD_ABOVE));

  // decision for one item
  always_comb begin
    waiting_for_ack_next      = waiting_for_ack;
    send_pending_next         = send_pending;
    pending_connect_kept_next = pending_connect_kept;
    last_tx_counter_next      = last_tx_counter;
    last_rx_counter_next      = last_rx_counter;
    ack_counter_kept_next     = ack_counter_kept;
    sent_time_next            = sent_time;
    resent_time_next          = resent_time;
    result                    = '0;
    result.send_kind          = SK_NONE;

    if (item.opcode == OP_QUEUE) begin
      last_tx_counter_next      = last_tx_counter + 8'd1;
      pending_connect_kept_next = item.pending_is_connect;
      sent_time_next            = now;
      send_pending_next         = 1'b1;
    end else if (waiting_for_ack) begin
      if (item.rx_valid) begin
        if (item.rx_is_ack) begin
          waiting_for_ack_next = 1'b0;
        end else begin
          result.send_kind     = SK_ACK;
          result.frame_counter = ack_counter_kept;
        end
      end else begin
        resent_time_next = resent_eff;
        if (timed_out) begin
          waiting_for_ack_next = 1'b0;
          result.proceed       = 1'b1;
          result.link_reset    = 1'b1;
        end else if (resend_due && !pending_connect_kept) begin
          resent_time_next     = now;
          result.send_kind     = SK_RESEND;
          result.frame_counter = last_tx_counter;
        end
      end
    end else if (send_pending) begin
      waiting_for_ack_next = 1'b1;
      send_pending_next    = 1'b0;
      sent_time_next       = now;
      result.send_kind     = SK_FIRST;
      result.frame_counter = last_tx_counter;
    end else if (item.rx_valid) begin
      if (!item.rx_is_ack) begin
        ack_counter_kept_next = last_tx_counter;
        result.send_kind      = SK_ACK;
        result.frame_counter  = last_tx_counter;
        result.proceed        = 1'b1;
        if (item.rx_is_connect) begin
          last_rx_counter_next = item.rx_counter;
          result.deliver       = 1'b1;
          result.link_reset    = 1'b1;
        end else if (rx_fresh) begin
          last_rx_counter_next = item.rx_counter;
          result.deliver       = 1'b1;
        end
      end
    end else begin
      result.proceed = 1'b1;
    end
  end

  // state update on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_for_ack      <= 1'b0;
      send_pending         <= 1'b0;
      pending_connect_kept <= 1'b0;
      last_tx_counter      <= '0;
      last_rx_counter      <= '0;
      ack_counter_kept     <= '0;
      sent_time            <= '0;
      resent_time          <= '0;
    end else if (fire) begin
      waiting_for_ack      <= waiting_for_ack_next;
      send_pending         <= send_pending_next;
      pending_connect_kept <= pending_connect_kept_next;
      last_tx_counter      <= last_tx_counter_next;
      last_rx_counter      <= last_rx_counter_next;
      ack_counter_kept     <= ack_counter_kept_next;
      sent_time            <= sent_time_next;
      resent_time          <= resent_time_next;
    end
  end

endmodule

// ----- hdl/stop_and_wait_link_control.sv -----
`timescale 1ns / 1ps
// an accepted item passes the input register, then the result register; a stalled result can hold it back
// throughput: one item per cycle while m_tready is high, set by the single decision pass in slc_core
// the result register frees the input side while a result waits to be taken
// reset: synchronous, active high; clears link state, both stage valids and
// loads the timeout and resend registers with their defaults
// ----------------------------------------------------------------------------
// stop_and_wait_link_control
// Stop-and-wait acknowledged link controller with stream ports and APB setup.
// ----------------------------------------------------------------------------
module stop_and_wait_link_control #(
  parameter int TIME_BITS = slc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // now_us[31:0], rx_valid[32], rx_is_ack[33], rx_is_connect[34],
  // rx_counter[42:35], pending_is_connect[43], zero[47:44]
  input  logic [slc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode[0]
  input  logic                            s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // frame_counter[7:0], proceed[8], deliver[9], link_reset[10], zero[15:11]
  output logic [slc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // send_kind[1:0]
  output logic [1:0]                      m_tuser,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import slc_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t result;
  result_t res_q;
  logic    advance;

  // configuration registers
  slc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage hand-off: item moves into the result register when it is free
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.opcode             <= s_tuser;
      item.now_us             <= s_tdata[31:0];
      item.rx_valid           <= s_tdata[32];
      item.rx_is_ack          <= s_tdata[33];
      item.rx_is_connect      <= s_tdata[34];
      item.rx_counter         <= s_tdata[42:35];
      item.pending_is_connect <= s_tdata[43];
    end
  end

  // link decision and state
  slc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_tuser = res_q.send_kind;
  assign m_tdata = {5'd0, res_q.link_reset, res_q.deliver, res_q.proceed,
                    res_q.frame_counter};

endmodule

// ----- hdl/slc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_checker
// Port-level assertions for the stop-and-wait link controller, bound to top.
// ----------------------------------------------------------------------------
module slc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import slc_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // nothing sent carries a zero counter
  a_none_ctr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == SK_NONE) |-> (m_tdata[7:0] == 8'd0))
    else $error("counter set with nothing sent");

  // a delivered frame is always acked and lets the application run
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[8] && (m_tuser == SK_ACK))
    else $error("delivery without ack or proceed");

  // a link reset always lets the application run, never with a resend
  a_link_reset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[8] &&
      (m_tuser == SK_NONE || m_tuser == SK_ACK))
    else $error("link reset with wrong companions");

endmodule

bind stop_and_wait_link_control slc_checker u_slc_checker (.*);

// ----- tb/stop_and_wait_link_control_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_link_control_tb
// Self-checking bench for the stop-and-wait link controller. A queue-fed
// stream driver and a result monitor run with random idle gaps on both sides.
// An in-bench model of the link state predicts each result, and the monitor
// compares it field by field. Register settings change between traffic
// phases through the APB port. The settings include the reset values, one,
// the maximum and zero.
// ----------------------------------------------------------------------------
module stop_and_wait_link_control_tb;
  import slc_pkg::*;

  localparam int ITEMS_PER_PHASE = 175;
  localparam int N_SETTINGS      = 5;
  localparam int DRAIN_CYCLES    = 6;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // now_us, rx_valid, rx_is_ack, rx_is_connect, rx_counter, pending_is_connect
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  // opcode
  logic                   s_tuser  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // frame_counter, proceed, deliver, link_reset
  logic [OUT_TDATA_W-1:0] m_tdata;
  // send_kind
  logic [1:0]             m_tuser;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [2:0]             paddr    = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;

  stop_and_wait_link_control #(.TIME_BITS(32)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // link state as the bench sees it
  logic        awaiting_ack      = 1'b0;
  logic        frame_queued      = 1'b0;
  logic        queued_is_connect = 1'b0;
  logic [7:0]  tx_seq            = 8'd0;
  logic [7:0]  rx_seq            = 8'd0;
  logic [7:0]  acked_seq         = 8'd0;
  logic [31:0] stamp_sent        = 32'd0;
  logic [31:0] stamp_resent      = 32'd0;
  logic [31:0] ack_limit         = ACK_TIMEOUT_RESET;
  logic [31:0] resend_gap        = RESEND_RESET;

  item_t       items_to_send[$];
  result_t     results_due[$];
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned fail_count     = 0;
  int unsigned n_results      = 0;
  int unsigned n_resends      = 0;
  int unsigned n_resets       = 0;
  int unsigned n_delivered    = 0;

  // stimulus generator state
  logic [31:0] gen_now  = 32'd0;
  logic [7:0]  peer_seq = 8'd0;

  // next result of the link for one accepted item
  function automatic result_t link_predict(input item_t it);
    result_t     r;
    logic [31:0] since_sent;
    logic [31:0] since_resend;
    r = '0;
    if (it.opcode == OP_QUEUE) begin
      tx_seq            = tx_seq + 8'd1;
      queued_is_connect = it.pending_is_connect;
      stamp_sent        = it.now_us;
      frame_queued      = 1'b1;
    end else if (awaiting_ack) begin
      if (it.rx_valid) begin
        // an ack ends the wait, anything else only gets acked
        if (it.rx_is_ack) begin
          awaiting_ack = 1'b0;
        end else begin
          r.send_kind     = SK_ACK;
          r.frame_counter = acked_seq;
        end
      end else begin
        if (stamp_resent < stamp_sent) stamp_resent = stamp_sent;
        since_sent   = it.now_us - stamp_sent;
        since_resend = it.now_us - stamp_resent;
        if (since_sent > ack_limit) begin
          awaiting_ack = 1'b0;
          r.proceed    = 1'b1;
          r.link_reset = 1'b1;
        end else if (since_resend > resend_gap && !queued_is_connect) begin
          stamp_resent    = it.now_us;
          r.send_kind     = SK_RESEND;
          r.frame_counter = tx_seq;
        end
      end
    end else if (frame_queued) begin
      awaiting_ack    = 1'b1;
      frame_queued    = 1'b0;
      stamp_sent      = it.now_us;
      r.send_kind     = SK_FIRST;
      r.frame_counter = tx_seq;
    end else if (it.rx_valid && !it.rx_is_ack) begin
      // received data or connect frame, always acked
      acked_seq       = tx_seq;
      r.send_kind     = SK_ACK;
      r.frame_counter = tx_seq;
      r.proceed       = 1'b1;
      if (it.rx_is_connect) begin
        rx_seq       = it.rx_counter;
        r.deliver    = 1'b1;
        r.link_reset = 1'b1;
      end else if (it.rx_counter > rx_seq ||
                   (it.rx_counter < WRAP_NEW_BELOW && rx_seq > WRAP_OLD_ABOVE)) begin
        rx_seq    = it.rx_counter;
        r.deliver = 1'b1;
      end
    end else if (!it.rx_valid) begin
      r.proceed = 1'b1;
    end
    return r;
  endfunction

  function automatic item_t make_item(input logic op, input logic [31:0] t,
                                      input logic rxv, input logic ack,
                                      input logic conn, input logic [7:0] ctr,
                                      input logic pconn);
    item_t it;
    it.opcode             = op;
    it.now_us             = t;
    it.rx_valid           = rxv;
    it.rx_is_ack          = ack;
    it.rx_is_connect      = conn;
    it.rx_counter         = ctr;
    it.pending_is_connect = pconn;
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // move time forward by steps scaled to the current register settings
  function automatic void advance_now();
    int unsigned r;
    logic [32:0] span;
    r = $urandom_range(0, 99);
    if (r < 40) span = 33'd3;
    else if (r < 75) span = {1'b0, resend_gap} + (resend_gap >> 1) + 33'd2;
    else if (r < 95) span = {1'b0, ack_limit} + (ack_limit >> 1) + 33'd2;
    else span = 33'h0_FFFF_FFFF;
    if (span[32]) span = 33'h0_FFFF_FFFF;
    gen_now = gen_now + $urandom_range(0, span[31:0]);
  endfunction

  // frame from the far end: mostly the next counter, some repeats and jumps
  function automatic item_t peer_frame();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) peer_seq = peer_seq + 8'd1;
    else if (r >= 85) peer_seq = 8'($urandom_range(0, 255));
    return make_item(OP_POLL, gen_now, 1'b1, 1'b0, $urandom_range(0, 99) < 8,
                     peer_seq, 1'($urandom_range(0, 1)));
  endfunction

  // random exchanges: outgoing frames with polls, incoming frames, idle polls, noise
  task automatic gen_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned r;
    int unsigned k;
    start = items_queued;
    while (items_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        advance_now();
        queue_item(make_item(OP_QUEUE, gen_now, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)),
                             $urandom_range(0, 99) < 15));
        k = $urandom_range(1, 8);
        repeat (k) begin
          advance_now();
          r = $urandom_range(0, 99);
          if (r < 25)
            queue_item(make_item(OP_POLL, gen_now, 1'b1, 1'b1, 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
          else if (r < 40)
            queue_item(peer_frame());
          else
            queue_item(make_item(OP_POLL, gen_now, 1'b0, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1))));
        end
      end else if (r < 80) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          advance_now();
          queue_item(peer_frame());
        end
      end else if (r < 95) begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          advance_now();
          queue_item(make_item(OP_POLL, gen_now, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
        end
      end else begin
        queue_item(make_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic reg_write(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_ACK_TIMEOUT) ack_limit = value;
    else resend_gap = value;
  endtask

  // input stream driver
  item_t       on_bus;
  int unsigned in_gap  = 0;
  int unsigned in_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(link_predict(on_bus));
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0 || items_to_send.size() == 0) begin
          if (in_gap > 0) in_gap--;
          s_tvalid <= 1'b0;
        end else begin
          on_bus   = items_to_send.pop_front();
          s_tdata  <= {4'b0, on_bus.pending_is_connect, on_bus.rx_counter,
                       on_bus.rx_is_connect, on_bus.rx_is_ack, on_bus.rx_valid,
                       on_bus.now_us};
          s_tuser  <= on_bus.opcode;
          s_tvalid <= 1'b1;
          // stretches with no idling now and then
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            in_gap = pick_idle();
            if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 80);
          end
        end
      end
    end
  end

  // result monitor and receiver stalls
  result_t     want;
  int unsigned out_stall = 0;
  int unsigned out_calm  = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (results_due.size() == 0) begin
          $error("unexpected result transfer: send_kind %0d, tdata %h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (m_tuser !== want.send_kind) begin
            $error("send_kind: expected %0d, got %0d", want.send_kind, m_tuser);
            fail_count++;
          end
          if (m_tdata[7:0] !== want.frame_counter) begin
            $error("frame_counter: expected %0d, got %0d", want.frame_counter, m_tdata[7:0]);
            fail_count++;
          end
          if (m_tdata[8] !== want.proceed) begin
            $error("proceed: expected %0d, got %0d", want.proceed, m_tdata[8]);
            fail_count++;
          end
          if (m_tdata[9] !== want.deliver) begin
            $error("deliver: expected %0d, got %0d", want.deliver, m_tdata[9]);
            fail_count++;
          end
          if (m_tdata[10] !== want.link_reset) begin
            $error("link_reset: expected %0d, got %0d", want.link_reset, m_tdata[10]);
            fail_count++;
          end
          if (want.send_kind == SK_RESEND) n_resends++;
          if (want.link_reset) n_resets++;
          if (want.deliver) n_delivered++;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          out_stall = pick_idle();
          if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  // register settings for the later phases
  logic [31:0] timeout_set [N_SETTINGS];
  logic [31:0] resend_set  [N_SETTINGS];

  initial begin
    timeout_set = '{32'd400, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd20};
    resend_set  = '{32'd50,  32'hFFFF_FFFF, 32'd1, 32'd0, 32'd5};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: idle poll with ignored fields set, ack not awaited, wrap freshness
    queue_item(make_item(OP_POLL,  32'd100, 1'b0, 1'b1, 1'b1, 8'd255, 1'b1));
    queue_item(make_item(OP_POLL,  32'd110, 1'b1, 1'b1, 1'b0, 8'd7,   1'b0));
    queue_item(make_item(OP_POLL,  32'd120, 1'b1, 1'b0, 1'b0, 8'd255, 1'b0));
    queue_item(make_item(OP_POLL,  32'd130, 1'b1, 1'b0, 1'b0, 8'd3,   1'b0));
    queue_item(make_item(OP_POLL,  32'd140, 1'b1, 1'b0, 1'b0, 8'd3,   1'b0));
    queue_item(make_item(OP_POLL,  32'd150, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0));
    // first send, frame while waiting, resend, ack with connect bit also set
    queue_item(make_item(OP_QUEUE, 32'd200, 1'b1, 1'b1, 1'b1, 8'd255, 1'b0));
    queue_item(make_item(OP_POLL,  32'd210, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0));
    queue_item(make_item(OP_POLL,  32'd220, 1'b1, 1'b0, 1'b0, 8'd4,   1'b0));
    queue_item(make_item(OP_POLL,  32'd30300, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'd30310, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'd30320, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0));
    // connect frame is never resent, then ack timeout, then incoming connect
    queue_item(make_item(OP_QUEUE, 32'd40000, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1));
    queue_item(make_item(OP_POLL,  32'd40010, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'd140010, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'd540011, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'd540020, 1'b1, 1'b0, 1'b1, 8'd9, 1'b0));
    // time wrap with resend, queue while waiting replaces the awaited frame
    queue_item(make_item(OP_QUEUE, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'hFFFF_FFF8, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'h0000_7540, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_QUEUE, 32'h0000_7550, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'h0000_7560, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'h0000_7570, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'h0000_7580, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
    queue_item(make_item(OP_POLL,  32'h0000_7590, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0));
    gen_now = 32'h0000_7590;

    // random traffic with register reset values
    gen_traffic(ITEMS_PER_PHASE);

    // random traffic under each further register setting
    for (int i = 0; i < N_SETTINGS; i++) begin
      wait_drained();
      reg_write(REG_ACK_TIMEOUT, timeout_set[i]);
      reg_write(REG_RESEND, resend_set[i]);
      gen_now = (i == N_SETTINGS - 1) ? 32'hFFFF_FF00 : $urandom;
      gen_traffic(ITEMS_PER_PHASE);
    end

    wait_drained();
    $display("ran %0d items / %0d results across %0d register settings",
             items_accepted, n_results, N_SETTINGS + 1);
    $display("seen %0d resends, %0d link resets, %0d deliveries",
             n_resends, n_resets, n_delivered);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/slc_pkg.sv
hdl/slc_regs.sv
hdl/slc_core.sv
hdl/stop_and_wait_link_control.sv
hdl/slc_checker.sv
tb/stop_and_wait_link_control_tb.sv
